[src/xcr_pkg.sv]
// Shared types and constants for the XMODEM checksum receiver.
// No dependencies; imported by every module of the block.
`default_nettype none

package xcr_pkg;

    localparam int RECORD_BYTES_DEF = 128;
    localparam int IDX_W            = 7;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CODE_ACK  = 8'd6;
    localparam logic [7:0] CODE_NAK  = 8'd21;
    localparam logic [7:0] CODE_EOT  = 8'd4;
    localparam logic [7:0] NAME_STOP = 8'd26;

    localparam logic       REQ_START = 1'b0;
    localparam logic       REQ_BYTE  = 1'b1;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_RECORD = 2'd1;
    localparam logic [1:0] KIND_REPLY  = 2'd2;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]       out_kind;
        logic [7:0]       data_byte;
        logic [IDX_W-1:0] byte_index;
        logic             name_char;
        logic [7:0]       reply_byte;
        logic             commit;
        logic             record_is_name;
        logic             end_of_file;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic      two;
        t_out_item r0;
        t_out_item r1;
    } t_res_pair;

endpackage

`default_nettype wire

[src/xcr_core.sv]
// Frame sequencer: holds the protocol state and turns one byte beat into
// one or two results. Depends on xcr_pkg.
`default_nettype none

module xcr_core #(
    parameter int RECORD_BYTES = xcr_pkg::RECORD_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_go,
    input  wire xcr_pkg::t_in_item i_item,
    output xcr_pkg::t_res_pair     o_res
);
    import xcr_pkg::*;

    localparam logic [2:0] PH_WAIT  = 3'd0;
    localparam logic [2:0] PH_SKIP  = 3'd1;
    localparam logic [2:0] PH_FRAME = 3'd2;
    localparam logic [2:0] PH_BLOCK = 3'd3;
    localparam logic [2:0] PH_CMPL  = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;
    localparam logic [2:0] PH_CHECK = 3'd6;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RECORD_BYTES - 1);

    logic [2:0]       r_phase,      n_phase;
    logic [1:0]       r_skip_left,  n_skip_left;
    logic [IDX_W-1:0] r_byte_count, n_byte_count;
    logic [7:0]       r_sum,        n_sum;
    logic [7:0]       r_block,      n_block;
    logic             r_name_taken, n_name_taken;
    logic             r_name_ended, n_name_ended;

    logic [7:0] b;
    logic       stop;
    logic       is_name;
    t_out_item  blank;

    always_comb begin
        b       = i_item.rx_byte;
        stop    = (b == NAME_STOP) || (b == 8'd0);
        is_name = (r_block == 8'd0) && !r_name_taken;
        blank   = '0;
        blank.last = 1'b1;

        n_phase      = r_phase;
        n_skip_left  = r_skip_left;
        n_byte_count = r_byte_count;
        n_sum        = r_sum;
        n_block      = r_block;
        n_name_taken = r_name_taken;
        n_name_ended = r_name_ended;

        o_res     = '0;
        o_res.r0  = blank;
        o_res.r1  = blank;

        if (i_item.req_type == REQ_START) begin
            n_phase                = PH_SKIP;
            n_skip_left            = 2'd2;
            o_res.r0.out_kind      = KIND_REPLY;
            o_res.r0.reply_byte    = CODE_NAK;
        end else begin
            unique case (r_phase)
                PH_SKIP: begin
                    n_skip_left = r_skip_left - 2'd1;
                    if (n_skip_left == 2'd0) begin
                        n_phase = PH_FRAME;
                    end
                end
                PH_FRAME: begin
                    if (b == CODE_EOT) begin
                        o_res.two              = 1'b1;
                        o_res.r0.out_kind      = KIND_REPLY;
                        o_res.r0.reply_byte    = CODE_ACK;
                        o_res.r0.end_of_file   = 1'b1;
                        o_res.r0.last          = 1'b0;
                        o_res.r1.out_kind      = KIND_REPLY;
                        o_res.r1.reply_byte    = CODE_ACK;
                        o_res.r1.end_of_file   = 1'b1;
                        n_name_taken           = 1'b0;
                        n_phase                = PH_WAIT;
                    end else begin
                        n_phase = PH_BLOCK;
                    end
                end
                PH_BLOCK: begin
                    n_block = b;
                    n_phase = PH_CMPL;
                end
                PH_CMPL: begin
                    n_byte_count = '0;
                    n_sum        = '0;
                    n_name_ended = 1'b0;
                    n_phase      = PH_DATA;
                end
                PH_DATA: begin
                    if (stop) begin
                        n_name_ended = 1'b1;
                    end
                    n_sum                = r_sum + b;
                    o_res.r0.out_kind    = KIND_RECORD;
                    o_res.r0.data_byte   = b;
                    o_res.r0.byte_index  = r_byte_count;
                    o_res.r0.name_char   = is_name && !r_name_ended && !stop;
                    if (r_byte_count >= LAST_IDX) begin
                        n_byte_count = '0;
                        n_phase      = PH_CHECK;
                    end else begin
                        n_byte_count = r_byte_count + 1'b1;
                    end
                end
                PH_CHECK: begin
                    o_res.r0.out_kind = KIND_REPLY;
                    if (b == r_sum) begin
                        if (is_name) begin
                            n_name_taken = 1'b1;
                        end
                        o_res.r0.reply_byte     = CODE_ACK;
                        o_res.r0.commit         = 1'b1;
                        o_res.r0.record_is_name = is_name;
                    end else begin
                        o_res.r0.reply_byte = CODE_NAK;
                    end
                    n_phase = PH_FRAME;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAIT;
            r_skip_left  <= '0;
            r_byte_count <= '0;
            r_sum        <= '0;
            r_block      <= '0;
            r_name_taken <= 1'b0;
            r_name_ended <= 1'b0;
        end else if (i_go) begin
            r_phase      <= n_phase;
            r_skip_left  <= n_skip_left;
            r_byte_count <= n_byte_count;
            r_sum        <= n_sum;
            r_block      <= n_block;
            r_name_taken <= n_name_taken;
            r_name_ended <= n_name_ended;
        end
    end

endmodule

`default_nettype wire

[src/xcr_outq.sv]
// Result queue: takes one or two results per beat, hands out one per beat.
// Depends on xcr_pkg.
`default_nettype none

module xcr_outq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_wr,
    input  wire xcr_pkg::t_res_pair i_res,
    output logic                    o_room,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output xcr_pkg::t_out_item      o_item
);
    import xcr_pkg::*;

    t_out_item         r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              rd;
    logic [QCNT_W-1:0] wr_n;

    always_comb begin
        o_valid = (r_cnt != '0);
        o_item  = r_q[r_rp];
        o_room  = (r_cnt <= QCNT_W'(QUEUE_DEPTH - 2));
        rd      = o_valid && !i_stall;
        wr_n    = i_wr ? (i_res.two ? QCNT_W'(2) : QCNT_W'(1)) : '0;
        n_wp    = r_wp + wr_n[QPTR_W-1:0];
        n_rp    = r_rp + QPTR_W'(rd);
        n_cnt   = r_cnt + wr_n - QCNT_W'(rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_wp] <= i_res.r0;
            if (i_res.two) begin
                r_q[r_wp + 1'b1] <= i_res.r1;
            end
        end
    end

endmodule

`default_nettype wire

[src/xmodem_checksum_receiver_top.sv]
// Top level of the XMODEM checksum receiver: input register, frame
// sequencer and result queue. Depends on xcr_pkg, xcr_core, xcr_outq.
//
//   channel  | handshake                 | beat payload
//   ---------+---------------------------+---------------------
//   input    | i_valid / o_stall         | i_item (t_in_item)
//   result   | o_valid / i_stall         | o_item (t_out_item)
//
// One input beat per cycle while o_stall is low; each beat is processed from
// the input register once the queue has room and gives one result (two for EOT).
// Results drain one per cycle, while i_stall is low, from a four-entry
// queue; the input stalls only while the queue lacks room for two results
// and the input register is full. Synchronous active-low reset returns to
// waiting for a start event and empties the queue.
`default_nettype none

module xmodem_checksum_receiver_top #(
    parameter int RECORD_BYTES = xcr_pkg::RECORD_BYTES_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire xcr_pkg::t_in_item i_item,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output xcr_pkg::t_out_item     o_item
);
    import xcr_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      room;
    logic      go;
    t_res_pair res;

    assign go      = r_in_valid && room;
    assign o_stall = r_in_valid && !room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_item <= i_item;
        end
    end

    xcr_core #(
        .RECORD_BYTES(RECORD_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_item  (r_in_item),
        .o_res   (res)
    );

    xcr_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (go),
        .i_res   (res),
        .o_room  (room),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire

[dv/xmodem_checksum_receiver_top_tb.sv]
// Self-checking testbench for xmodem_checksum_receiver_top: drives start events and
// received bytes, predicts every result beat and checks each one as it drains.
// Depends on xcr_pkg and the RTL under src/.

module xmodem_checksum_receiver_top_tb;

    import xcr_pkg::*;

    localparam int REC_LEN     = RECORD_BYTES_DEF;
    localparam int IDLE_LIMIT  = 4000;
    localparam int BEAT_TARGET = 440;

    class rx_scoreboard;

        typedef enum logic [2:0] {
            ST_IDLE, ST_DISCARD, ST_HEADER, ST_BLOCK_NUM, ST_COMPLEMENT, ST_RECORD, ST_CHECKSUM
        } rx_state_e;

        rx_state_e        st;
        logic [1:0]       discard_left;
        logic [IDX_W-1:0] rec_idx;
        logic [7:0]       rec_sum;
        logic [7:0]       blk_num;
        logic             name_done;
        logic             name_closed;
        t_out_item        pending_results[$];
        int               errors;

        function new();
            st           = ST_IDLE;
            discard_left = '0;
            rec_idx      = '0;
            rec_sum      = '0;
            blk_num      = '0;
            name_done    = 1'b0;
            name_closed  = 1'b0;
            errors       = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_rx_beat(t_in_item beat);
            t_out_item r;
            logic      stop;
            logic      is_name;
            r      = '0;
            r.last = 1'b1;
            if (beat.req_type == REQ_START) begin
                st           = ST_DISCARD;
                discard_left = 2'd2;
                r.out_kind   = KIND_REPLY;
                r.reply_byte = CODE_NAK;
                pending_results.push_back(r);
                return;
            end
            case (st)
                ST_DISCARD: begin
                    discard_left = discard_left - 2'd1;
                    if (discard_left == 2'd0) st = ST_HEADER;
                end
                ST_HEADER: begin
                    if (beat.rx_byte == CODE_EOT) begin
                        r.out_kind    = KIND_REPLY;
                        r.reply_byte  = CODE_ACK;
                        r.end_of_file = 1'b1;
                        r.last        = 1'b0;
                        pending_results.push_back(r);
                        r.last        = 1'b1;
                        name_done     = 1'b0;
                        st            = ST_IDLE;
                    end else begin
                        st = ST_BLOCK_NUM;
                    end
                end
                ST_BLOCK_NUM: begin
                    blk_num = beat.rx_byte;
                    st      = ST_COMPLEMENT;
                end
                ST_COMPLEMENT: begin
                    rec_idx     = '0;
                    rec_sum     = '0;
                    name_closed = 1'b0;
                    st          = ST_RECORD;
                end
                ST_RECORD: begin
                    stop        = (beat.rx_byte == NAME_STOP) || (beat.rx_byte == 8'h00);
                    r.out_kind  = KIND_RECORD;
                    r.data_byte = beat.rx_byte;
                    r.byte_index = rec_idx;
                    r.name_char = (blk_num == 8'h00) && !name_done && !name_closed && !stop;
                    if (stop) name_closed = 1'b1;
                    rec_sum = rec_sum + beat.rx_byte;
                    if (rec_idx == IDX_W'(REC_LEN - 1)) begin
                        rec_idx = '0;
                        st      = ST_CHECKSUM;
                    end else begin
                        rec_idx = rec_idx + 1'b1;
                    end
                end
                ST_CHECKSUM: begin
                    r.out_kind = KIND_REPLY;
                    if (beat.rx_byte == rec_sum) begin
                        is_name = (blk_num == 8'h00) && !name_done;
                        if (is_name) name_done = 1'b1;
                        r.reply_byte     = CODE_ACK;
                        r.commit         = 1'b1;
                        r.record_is_name = is_name;
                    end else begin
                        r.reply_byte = CODE_NAK;
                    end
                    st = ST_HEADER;
                end
                default: ;
            endcase
            pending_results.push_back(r);
        endfunction

        function void compare_field(string fname, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t mismatch %s: expected %0d actual %0d", $time, fname, want, got);
                errors++;
            end
        endfunction

        function void check_result_beat(t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result beat: expected none actual kind %0d",
                         $time, got.out_kind);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("out_kind", want.out_kind, got.out_kind);
            compare_field("data_byte", want.data_byte, got.data_byte);
            compare_field("byte_index", want.byte_index, got.byte_index);
            compare_field("name_char", want.name_char, got.name_char);
            compare_field("reply_byte", want.reply_byte, got.reply_byte);
            compare_field("commit", want.commit, got.commit);
            compare_field("record_is_name", want.record_is_name, got.record_is_name);
            compare_field("end_of_file", want.end_of_file, got.end_of_file);
            compare_field("last", want.last, got.last);
        endfunction

    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_valid;
    logic         o_stall;
    t_in_item     i_item;
    logic         o_valid;
    logic         i_stall;
    t_out_item    o_item;

    rx_scoreboard sb;
    int           beats_sent;
    int           idle_cycles;
    bit           tx_calm;

    xmodem_checksum_receiver_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result_beat(o_item);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (!(i_rst_n === 1'b1 && idle_cycles >= IDLE_LIMIT)) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int n;
        int sel;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            sel = $urandom_range(0, 9);
            if (sel < 3) begin
                i_stall <= 1'b0;
                n = $urandom_range(20, 150);
            end else if (sel < 8) begin
                i_stall <= 1'b1;
                n = $urandom_range(1, 3);
            end else if (sel < 9) begin
                i_stall <= 1'b1;
                n = $urandom_range(10, 60);
            end else begin
                i_stall <= 1'b0;
                n = $urandom_range(1, 4);
            end
            repeat (n - 1) @(negedge i_clk);
        end
    end

    function automatic int pick_gap();
        int r;
        if (tx_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // call at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_beat(input logic req, input logic [7:0] b);
        t_in_item beat;
        int       gap;
        beat.req_type = req;
        beat.rx_byte  = b;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= beat;
        do @(posedge i_clk); while (o_stall);
        sb.note_rx_beat(beat);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic restart_session();
        send_beat(REQ_START, 8'($urandom_range(0, 255)));
        send_beat(REQ_BYTE, 8'($urandom_range(0, 255)));
        send_beat(REQ_BYTE, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_frame();
        logic [7:0] blk;
        logic [7:0] sum;
        logic [7:0] d;
        logic [7:0] stop_val;
        int         term_mode;
        int         stop_at;
        int         abort_at;
        int         i;
        sum = '0;
        d = ($urandom_range(0, 9) != 0) ? 8'h01 : 8'($urandom_range(0, 255));
        if (d == CODE_EOT) d = 8'h02;
        send_beat(REQ_BYTE, d);
        blk = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'($urandom_range(0, 255));
        send_beat(REQ_BYTE, blk);
        send_beat(REQ_BYTE, ($urandom_range(0, 3) != 0) ? ~blk : 8'($urandom_range(0, 255)));
        term_mode = $urandom_range(0, 2);
        stop_at   = $urandom_range(0, REC_LEN - 1);
        stop_val  = ($urandom_range(0, 1) != 0) ? NAME_STOP : 8'h00;
        abort_at  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, REC_LEN) : -1;
        for (i = 0; i < REC_LEN; i++) begin
            if (i == abort_at) begin
                restart_session();
                return;
            end
            d = 8'($urandom_range(0, 255));
            if (term_mode != 2 && (d == NAME_STOP || d == 8'h00)) d = 8'h20;
            if (term_mode == 1 && i == stop_at) d = stop_val;
            sum = sum + d;
            send_beat(REQ_BYTE, d);
        end
        if (abort_at == REC_LEN) begin
            restart_session();
            return;
        end
        send_beat(REQ_BYTE, ($urandom_range(0, 3) != 0) ? sum : sum + 8'($urandom_range(1, 255)));
    endtask

    initial begin
        int sel;
        sb          = new();
        beats_sent  = 0;
        tx_calm     = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_item      = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_beat(REQ_BYTE, 8'hFF);
        send_beat(REQ_BYTE, 8'h00);
        send_beat(REQ_START, 8'hFF);
        send_beat(REQ_BYTE, CODE_EOT);
        send_beat(REQ_BYTE, 8'hAA);
        send_beat(REQ_BYTE, CODE_EOT);
        send_beat(REQ_BYTE, 8'h55);
        send_beat(REQ_START, 8'h00);
        send_beat(REQ_START, 8'h80);
        send_beat(REQ_BYTE, 8'h01);
        send_beat(REQ_BYTE, 8'h01);
        send_beat(REQ_BYTE, 8'h01);
        send_beat(REQ_BYTE, 8'h00);
        send_beat(REQ_BYTE, 8'hFF);
        send_beat(REQ_BYTE, 8'h41);
        send_beat(REQ_BYTE, NAME_STOP);
        send_beat(REQ_BYTE, 8'h42);
        send_beat(REQ_START, 8'h7F);
        send_beat(REQ_BYTE, 8'h00);
        send_beat(REQ_BYTE, 8'hFF);
        send_beat(REQ_BYTE, 8'hFF);
        send_beat(REQ_BYTE, 8'hFF);
        send_beat(REQ_START, 8'h01);
        drain_results();

        while (beats_sent < BEAT_TARGET) begin
            tx_calm = ($urandom_range(0, 4) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                send_beat(REQ_BYTE, 8'($urandom_range(0, 255)));
            end else if (sel < 12) begin
                send_beat(REQ_START, 8'($urandom_range(0, 255)));
            end else begin
                restart_session();
                repeat ($urandom_range(0, 2)) begin
                    send_frame();
                    if ($urandom_range(0, 3) == 0) drain_results();
                end
                if ($urandom_range(0, 2) != 0) send_beat(REQ_BYTE, CODE_EOT);
            end
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
